FILE: rtl/prt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types, widths and constants of the pose registration transform.
// ----------------------------------------------------------------------------
package prt_pkg;

	// Internal widths, sized for the widest FRAC_BITS / COEF_WIDTH setting
	localparam int ROT_W  = 35;  // rotation matrix element, Q.(2*FRAC_BITS)
	localparam int RB_W   = 51;  // rot * bias product
	localparam int RBS_W  = 53;  // sum of three rot * bias products
	localparam int PNT_W  = 40;  // biased point, Q7.8
	localparam int AP_W   = 56;  // coefficient * point product
	localparam int APS_W  = 58;  // sum of three coefficient * point products
	localparam int QT_W   = 35;  // first quaternion product
	localparam int QP_W   = 51;  // partial of the second quaternion product
	localparam int QS_W   = 53;  // second quaternion product

	typedef logic signed [15:0]      s16_t;
	typedef s16_t [2:0]              vec3_t;
	typedef logic signed [ROT_W-1:0] rot_elem_t;
	typedef rot_elem_t [8:0]         rot_mat_t;
	typedef logic [2:0][63:0]        row_set_t;

	// Hamilton product: term a of result k multiplies a[a] by b[a ^ k];
	// bit a of QNEG[k] marks a subtracted term.
	localparam logic [3:0][3:0] QNEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

	typedef enum logic [2:0] {
		CFG_ROW0      = 3'd0,
		CFG_ROW1      = 3'd1,
		CFG_ROW2      = 3'd2,
		CFG_BIAS_OFS  = 3'd3,
		CFG_REG_QUAT  = 3'd4,
		CFG_BIAS_QUAT = 3'd5
	} cfg_idx_t;

	localparam logic [63:0] ROW0_RST      = 64'h0000_0000_0000_2000;
	localparam logic [63:0] ROW1_RST      = 64'h0000_0000_2000_0000;
	localparam logic [63:0] ROW2_RST      = 64'h0000_2000_0000_0000;
	localparam logic [47:0] BIAS_OFS_RST  = 48'h0;
	localparam logic [63:0] QUAT_RST      = 64'h0000_0000_0000_2000;

	typedef struct packed {
		logic [31:0]        stamp;
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
		logic signed [15:0] raw_z;
		logic signed [15:0] raw_qw;
		logic signed [15:0] raw_qx;
		logic signed [15:0] raw_qy;
		logic signed [15:0] raw_qz;
	} pose_in_t;

	typedef struct packed {
		logic [31:0]        out_stamp;
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
		logic signed [15:0] out_qw;
		logic signed [15:0] out_qx;
		logic signed [15:0] out_qy;
		logic signed [15:0] out_qz;
	} pose_out_t;

endpackage
`default_nettype wire

FILE: rtl/pose_registration_transform_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pose_registration_transform_core
// Applies bias and registration to raw tracker poses (position + quaternion).
// ----------------------------------------------------------------------------
// A pose is taken on every cycle in which start is high; busy never rises, so
// a new pose may follow every clock. Each pose produces exactly one result,
// presented on result for one cycle with done high once it has passed the
// pipeline: three multiplier ranks on the position path (quaternion to
// matrix, then rot*bias, then A*p), each followed by its sum stage, and two
// on the orientation path (the two Hamilton products), each followed by its
// sum stage, then a rounding and a saturation stage. The receiver must take
// the result in the cycle done is high. Configuration writes are always
// accepted and should only be made while no pose is in flight.
module pose_registration_transform_core #(
	parameter int FRAC_BITS  = 13,
	parameter int COEF_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  prt_pkg::pose_in_t  pose,
	output logic               done,
	output prt_pkg::pose_out_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  prt_pkg::cfg_idx_t  cfg_index,
	input  logic [63:0]        cfg_data
);
	import prt_pkg::*;

	row_set_t    rows_q;
	logic [47:0] bias_ofs_q;
	logic [63:0] reg_quat_q;
	logic [63:0] bias_quat_q;

	logic        in_beat;
	logic [31:0] stamp_s1, stamp_s2, stamp_s3, stamp_s4, stamp_s5, stamp_s6;

	logic        rm_valid;
	rot_mat_t    rm_rot;
	vec3_t       rm_pos;
	logic        xf_valid;
	vec3_t       xf_pos;
	logic        qt_valid;
	s16_t        qt_q [4];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign in_beat   = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[0]   <= ROW0_RST;
			rows_q[1]   <= ROW1_RST;
			rows_q[2]   <= ROW2_RST;
			bias_ofs_q  <= BIAS_OFS_RST;
			reg_quat_q  <= QUAT_RST;
			bias_quat_q <= QUAT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROW0:      rows_q[0]   <= cfg_data;
				CFG_ROW1:      rows_q[1]   <= cfg_data;
				CFG_ROW2:      rows_q[2]   <= cfg_data;
				CFG_BIAS_OFS:  bias_ofs_q  <= cfg_data[47:0];
				CFG_REG_QUAT:  reg_quat_q  <= cfg_data;
				CFG_BIAS_QUAT: bias_quat_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// timestamp delay line, matches the six-stage datapath
	always_ff @(posedge clk) begin
		stamp_s1 <= pose.stamp;
		stamp_s2 <= stamp_s1;
		stamp_s3 <= stamp_s2;
		stamp_s4 <= stamp_s3;
		stamp_s5 <= stamp_s4;
		stamp_s6 <= stamp_s5;
	end

	prt_rotmat #(
		.FRAC_BITS (FRAC_BITS)
	) u_rotmat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_beat),
		.pose      (pose),
		.out_valid (rm_valid),
		.rot       (rm_rot),
		.pos       (rm_pos)
	);

	prt_xform #(
		.FRAC_BITS  (FRAC_BITS),
		.COEF_WIDTH (COEF_WIDTH)
	) u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rm_valid),
		.rot       (rm_rot),
		.pos       (rm_pos),
		.rows      (rows_q),
		.bias      (bias_ofs_q),
		.out_valid (xf_valid),
		.out_pos   (xf_pos)
	);

	prt_quat #(
		.FRAC_BITS  (FRAC_BITS),
		.COEF_WIDTH (COEF_WIDTH)
	) u_quat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_beat),
		.pose      (pose),
		.reg_quat  (reg_quat_q),
		.bias_quat (bias_quat_q),
		.out_valid (qt_valid),
		.out_q     (qt_q)
	);

	assign done             = xf_valid && qt_valid;
	assign result.out_stamp = stamp_s6;
	assign result.out_x     = xf_pos[0];
	assign result.out_y     = xf_pos[1];
	assign result.out_z     = xf_pos[2];
	assign result.out_qw    = qt_q[0];
	assign result.out_qx    = qt_q[1];
	assign result.out_qy    = qt_q[2];
	assign result.out_qz    = qt_q[3];

endmodule
`default_nettype wire

FILE: rtl/prt_rotmat.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prt_rotmat
// Raw quaternion to rotation matrix, two stages: products, then sums.
// The raw position rides along with the matrix.
// ----------------------------------------------------------------------------
module prt_rotmat #(
	parameter int FRAC_BITS = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  prt_pkg::pose_in_t  pose,
	output logic               out_valid,
	output prt_pkg::rot_mat_t  rot,
	output prt_pkg::vec3_t     pos
);
	import prt_pkg::*;

	localparam logic signed [ROT_W-1:0] ONE =
		{{(ROT_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

	// product order: xx yy zz xy xz yz xw yw zw
	logic signed [31:0] prod_s1 [9];
	vec3_t              pos_s1;
	logic               valid_s1;

	rot_mat_t           rot_s2;
	vec3_t              pos_s2;
	logic               valid_s2;

	logic signed [ROT_W-1:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			prod_s1[0] <= pose.raw_qx * pose.raw_qx;
			prod_s1[1] <= pose.raw_qy * pose.raw_qy;
			prod_s1[2] <= pose.raw_qz * pose.raw_qz;
			prod_s1[3] <= pose.raw_qx * pose.raw_qy;
			prod_s1[4] <= pose.raw_qx * pose.raw_qz;
			prod_s1[5] <= pose.raw_qy * pose.raw_qz;
			prod_s1[6] <= pose.raw_qx * pose.raw_qw;
			prod_s1[7] <= pose.raw_qy * pose.raw_qw;
			prod_s1[8] <= pose.raw_qz * pose.raw_qw;
			pos_s1     <= {pose.raw_z, pose.raw_y, pose.raw_x};
		end
	end

	always_comb begin
		xx = ROT_W'(prod_s1[0]);
		yy = ROT_W'(prod_s1[1]);
		zz = ROT_W'(prod_s1[2]);
		xy = ROT_W'(prod_s1[3]);
		xz = ROT_W'(prod_s1[4]);
		yz = ROT_W'(prod_s1[5]);
		xw = ROT_W'(prod_s1[6]);
		yw = ROT_W'(prod_s1[7]);
		zw = ROT_W'(prod_s1[8]);
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rot_s2[0] <= ONE - ((yy + zz) <<< 1);
			rot_s2[1] <= (xy - zw) <<< 1;
			rot_s2[2] <= (xz + yw) <<< 1;
			rot_s2[3] <= (xy + zw) <<< 1;
			rot_s2[4] <= ONE - ((xx + zz) <<< 1);
			rot_s2[5] <= (yz - xw) <<< 1;
			rot_s2[6] <= (xz - yw) <<< 1;
			rot_s2[7] <= (yz + xw) <<< 1;
			rot_s2[8] <= ONE - ((xx + yy) <<< 1);
			pos_s2    <= pos_s1;
		end
	end

	assign out_valid = valid_s2;
	assign rot       = rot_s2;
	assign pos       = pos_s2;

endmodule
`default_nettype wire

FILE: rtl/prt_xform.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prt_xform
// Position path: p = R*b + t, then out = A*p + T with saturation.
// Stages 3..6: rot*bias products, round and add t, A*p products, final sum.
// ----------------------------------------------------------------------------
module prt_xform #(
	parameter int FRAC_BITS  = 13,
	parameter int COEF_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  prt_pkg::rot_mat_t  rot,
	input  prt_pkg::vec3_t     pos,
	input  prt_pkg::row_set_t  rows,
	input  logic [47:0]        bias,
	output logic               out_valid,
	output prt_pkg::vec3_t     out_pos
);
	import prt_pkg::*;

	localparam logic signed [RBS_W-1:0] HALF_RB =
		{{(RBS_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS - 1);
	localparam logic signed [APS_W-1:0] HALF_AP =
		{{(APS_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

	logic signed [RB_W-1:0]  rb_s3 [9];
	vec3_t                   pos_s3;
	logic signed [PNT_W-1:0] pnt_s4 [3];
	logic signed [AP_W-1:0]  ap_s5 [9];
	vec3_t                   out_s6;
	logic                    valid_s3, valid_s4, valid_s5, valid_s6;

	logic signed [RBS_W-1:0] rb_sum [3];
	logic signed [PNT_W-1:0] pnt_n [3];
	logic signed [APS_W-1:0] ap_sum [3];
	s16_t                    out_n [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// stage 3: R[i][j] * b[j]
	always_ff @(posedge clk) begin
		if (in_valid) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					rb_s3[3*i+j] <= $signed(rot[3*i+j]) * $signed(bias[16*j +: 16]);
				end
			end
			pos_s3 <= pos;
		end
	end

	// stage 4: round half up to Q7.8, add raw position (no saturation)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rb_sum[i] = RBS_W'(rb_s3[3*i]) + RBS_W'(rb_s3[3*i+1])
				+ RBS_W'(rb_s3[3*i+2]) + HALF_RB;
			pnt_n[i] = PNT_W'(rb_sum[i] >>> (2 * FRAC_BITS))
				+ PNT_W'($signed(pos_s3[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			for (int i = 0; i < 3; i++) begin
				pnt_s4[i] <= pnt_n[i];
			end
		end
	end

	// stage 5: A[i][j] * p[j], coefficient from the low COEF_WIDTH lane bits
	always_ff @(posedge clk) begin
		if (valid_s4) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					ap_s5[3*i+j] <= $signed(rows[i][16*j +: COEF_WIDTH]) * pnt_s4[j];
				end
			end
		end
	end

	// stage 6: round, add translation, saturate to 16 bits
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ap_sum[i] = ((APS_W'(ap_s5[3*i]) + APS_W'(ap_s5[3*i+1])
				+ APS_W'(ap_s5[3*i+2]) + HALF_AP) >>> FRAC_BITS)
				+ APS_W'($signed(rows[i][63:48]));
			if (ap_sum[i][APS_W-1:15] == '0 || ap_sum[i][APS_W-1:15] == '1) begin
				out_n[i] = ap_sum[i][15:0];
			end else if (ap_sum[i][APS_W-1]) begin
				out_n[i] = 16'sh8000;
			end else begin
				out_n[i] = 16'sh7FFF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s5) begin
			out_s6 <= {out_n[2], out_n[1], out_n[0]};
		end
	end

	assign out_valid = valid_s6;
	assign out_pos   = out_s6;

endmodule
`default_nettype wire

FILE: rtl/prt_quat.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prt_quat
// Orientation path: reg_quat * raw * bias_quat, rounded and saturated to
// the COEF_WIDTH range. Six stages, aligned with the position path.
// ----------------------------------------------------------------------------
module prt_quat #(
	parameter int FRAC_BITS  = 13,
	parameter int COEF_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  prt_pkg::pose_in_t pose,
	input  logic [63:0]       reg_quat,
	input  logic [63:0]       bias_quat,
	output logic              out_valid,
	output prt_pkg::s16_t     out_q [4]
);
	import prt_pkg::*;

	localparam logic signed [QS_W-1:0] HALF_Q =
		{{(QS_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS - 1);
	localparam logic [15:0] Q_MAX = 16'((1 << (COEF_WIDTH - 1)) - 1);

	logic signed [15:0]     q_in [4];
	logic signed [31:0]     p1_s1 [16];
	logic signed [QT_W-1:0] tmp_s2 [4];
	logic signed [QP_W-1:0] p2_s3 [16];
	logic signed [QS_W-1:0] res_s4 [4];
	logic signed [QS_W-1:0] rnd_s5 [4];
	s16_t                   out_s6 [4];
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	logic signed [QT_W-1:0] tmp_n [4];
	logic signed [QS_W-1:0] res_n [4];
	s16_t                   sat_n [4];

	assign q_in[0] = pose.raw_qw;
	assign q_in[1] = pose.raw_qx;
	assign q_in[2] = pose.raw_qy;
	assign q_in[3] = pose.raw_qz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// stage 1: reg_quat[a] * raw[b]
	always_ff @(posedge clk) begin
		if (in_valid) begin
			for (int a = 0; a < 4; a++) begin
				for (int b = 0; b < 4; b++) begin
					p1_s1[4*a+b] <= $signed(reg_quat[16*a +: COEF_WIDTH]) * q_in[b];
				end
			end
		end
	end

	// stage 2: first Hamilton product, exact
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			tmp_n[k] = '0;
			for (int a = 0; a < 4; a++) begin
				if (QNEG[k][a]) begin
					tmp_n[k] = tmp_n[k] - QT_W'(p1_s1[4*a + (a ^ k)]);
				end else begin
					tmp_n[k] = tmp_n[k] + QT_W'(p1_s1[4*a + (a ^ k)]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			tmp_s2 <= tmp_n;
		end
	end

	// stage 3: tmp[a] * bias_quat[b]
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			for (int a = 0; a < 4; a++) begin
				for (int b = 0; b < 4; b++) begin
					p2_s3[4*a+b] <= tmp_s2[a] * $signed(bias_quat[16*b +: COEF_WIDTH]);
				end
			end
		end
	end

	// stage 4: second Hamilton product, exact
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			res_n[k] = '0;
			for (int a = 0; a < 4; a++) begin
				if (QNEG[k][a]) begin
					res_n[k] = res_n[k] - QS_W'(p2_s3[4*a + (a ^ k)]);
				end else begin
					res_n[k] = res_n[k] + QS_W'(p2_s3[4*a + (a ^ k)]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			res_s4 <= res_n;
		end
	end

	// stage 5: round half up by 2*FRAC_BITS
	always_ff @(posedge clk) begin
		if (valid_s4) begin
			for (int k = 0; k < 4; k++) begin
				rnd_s5[k] <= (res_s4[k] + HALF_Q) >>> (2 * FRAC_BITS);
			end
		end
	end

	// stage 6: saturate to COEF_WIDTH signed, sign-extend into the lane
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (rnd_s5[k][QS_W-1:COEF_WIDTH-1] == '0
					|| rnd_s5[k][QS_W-1:COEF_WIDTH-1] == '1) begin
				sat_n[k] = 16'($signed(rnd_s5[k][COEF_WIDTH-1:0]));
			end else if (rnd_s5[k][QS_W-1]) begin
				sat_n[k] = ~Q_MAX;
			end else begin
				sat_n[k] = Q_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s5) begin
			out_s6 <= sat_n;
		end
	end

	assign out_valid = valid_s6;
	assign out_q     = out_s6;

endmodule
`default_nettype wire

FILE: tb/tb_pose_registration_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pose_registration_transform_core
// Self-checking bench for the pose registration transform. A short directed
// table runs first: pass-through rows under the reset registers, then rows
// under rotated, biased and saturating setups. Randomized phases follow, each
// with a fresh register set. A bit-exact predictor covers every row whose
// expected pose is not typed into the table. Results are checked in order.
// ----------------------------------------------------------------------------
module tb_pose_registration_transform_core;
	import prt_pkg::*;

	localparam int FRAC     = 13;
	localparam int COEF_W   = 16;
	localparam int PIPE_LAT = 6;
	localparam int N_PHASES = 14;
	localparam int PHASE_ITEMS = 140;
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;

	typedef longint quat4_t [4];

	typedef struct {
		int        phase;
		bit        typed;
		pose_in_t  pin;
		pose_out_t want;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	pose_in_t   pose;
	logic       done;
	pose_out_t  result;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_idx_t   cfg_index;
	logic [63:0] cfg_data;

	// shadow copy of the block's registers
	logic [63:0] row_cfg [3];
	logic [47:0] bias_ofs_cfg;
	logic [63:0] reg_quat_cfg;
	logic [63:0] bias_quat_cfg;

	pose_out_t expected_poses[$];
	dir_row_t  dir_rows[$];
	int        mismatches = 0;
	bit        no_idle = 1'b0;

	pose_registration_transform_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pose      (pose),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic longint lane_s16(logic [63:0] r, int i);
		logic [15:0] v;
		v = r[16*i +: 16];
		return longint'($signed(v));
	endfunction

	function automatic longint lane_coef(logic [63:0] r, int i);
		logic [15:0] v;
		longint c;
		v = r[16*i +: 16];
		c = longint'(v) & ((longint'(1) << COEF_W) - 1);
		if (c[COEF_W-1])
			c = c - (longint'(1) << COEF_W);
		return c;
	endfunction

	// round half up: add half an LSB, then arithmetic shift (floor)
	function automatic longint rnd_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -(longint'(1) << (w - 1));
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic void hamilton(input quat4_t a, input quat4_t b, output quat4_t r);
		r[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
		r[1] = a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2];
		r[2] = a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1];
		r[3] = a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0];
	endfunction

	function automatic pose_out_t register_pose(pose_in_t pin);
		longint t[3];
		quat4_t q, rq, bq, m, r;
		longint rot[3][3];
		longint b[3], p[3];
		longint acc, one, w, x, y, z;
		logic [15:0] pos16[3];
		logic [15:0] q16[4];
		one = longint'(1) << (2 * FRAC);
		t[0] = longint'($signed(pin.raw_x));
		t[1] = longint'($signed(pin.raw_y));
		t[2] = longint'($signed(pin.raw_z));
		q[0] = longint'($signed(pin.raw_qw));
		q[1] = longint'($signed(pin.raw_qx));
		q[2] = longint'($signed(pin.raw_qy));
		q[3] = longint'($signed(pin.raw_qz));
		for (int i = 0; i < 4; i++) begin
			rq[i] = lane_coef(reg_quat_cfg, i);
			bq[i] = lane_coef(bias_quat_cfg, i);
		end
		for (int i = 0; i < 3; i++)
			b[i] = lane_s16({16'h0, bias_ofs_cfg}, i);
		w = q[0];
		x = q[1];
		y = q[2];
		z = q[3];
		// unit-quaternion formula applied as is, even for non-unit input
		rot[0][0] = one - 2 * (y * y + z * z);
		rot[0][1] = 2 * (x * y - z * w);
		rot[0][2] = 2 * (x * z + y * w);
		rot[1][0] = 2 * (x * y + z * w);
		rot[1][1] = one - 2 * (x * x + z * z);
		rot[1][2] = 2 * (y * z - x * w);
		rot[2][0] = 2 * (x * z - y * w);
		rot[2][1] = 2 * (y * z + x * w);
		rot[2][2] = one - 2 * (x * x + y * y);
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += rot[i][j] * b[j];
			p[i] = t[i] + rnd_shift(acc, 2 * FRAC);
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += lane_coef(row_cfg[i], j) * p[j];
			acc = rnd_shift(acc, FRAC) + lane_s16(row_cfg[i], 3);
			pos16[i] = 16'(clamp(acc, 16));
		end
		hamilton(rq, q, m);
		hamilton(m, bq, r);
		for (int i = 0; i < 4; i++)
			q16[i] = 16'(clamp(rnd_shift(r[i], 2 * FRAC), COEF_W));
		return {pin.stamp, pos16[0], pos16[1], pos16[2], q16[0], q16[1], q16[2], q16[3]};
	endfunction

	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 16'($urandom);
			5: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
			6: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(0, 16'h4000)) - 16'h2000;
		endcase
	endfunction

	// tame lanes stay within +-1.0 in Q2.13
	function automatic logic [15:0] rand_lane(bit tame);
		if (tame)
			return 16'($urandom_range(0, 16'h4000)) - 16'h2000;
		return rand_word();
	endfunction

	task automatic add_row(int phase, bit typed, pose_in_t pin, pose_out_t want);
		dir_row_t row;
		row.phase = phase;
		row.typed = typed;
		row.pin = pin;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	task automatic send_pose(pose_in_t pin, pose_out_t want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		pose <= pin;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_poses.push_back(want);
	endtask

	// leaves cfg_valid high so back-to-back beats need no extra edge
	task automatic write_reg(logic [2:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= cfg_idx_t'(idx);
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (cfg_idx_t'(idx))
			CFG_ROW0:      row_cfg[0] = data;
			CFG_ROW1:      row_cfg[1] = data;
			CFG_ROW2:      row_cfg[2] = data;
			CFG_BIAS_OFS:  bias_ofs_cfg = data[47:0];
			CFG_REG_QUAT:  reg_quat_cfg = data;
			CFG_BIAS_QUAT: bias_quat_cfg = data;
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [63:0] r0, r1, r2, bias, rq, bq, input bit spare);
		write_reg(CFG_ROW0, r0);
		write_reg(CFG_ROW1, r1);
		write_reg(CFG_ROW2, r2);
		write_reg(CFG_BIAS_OFS, bias);
		write_reg(CFG_REG_QUAT, rq);
		write_reg(CFG_BIAS_QUAT, bq);
		// indexes past the register list must leave everything untouched
		if (spare) begin
			write_reg(CFG_SPARE_LO, {$urandom, $urandom});
			write_reg(CFG_SPARE_HI, {$urandom, $urandom});
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		start <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t %s: expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		pose_out_t want;
		if (arst_n && done) begin
			if (expected_poses.size() == 0) begin
				mismatches++;
				$display("%0t result beat with nothing pending: expected none, got %h",
					$time, result);
			end else begin
				want = expected_poses.pop_front();
				check_field("out_stamp", want.out_stamp, result.out_stamp);
				check_field("out_x", want.out_x, result.out_x);
				check_field("out_y", want.out_y, result.out_y);
				check_field("out_z", want.out_z, result.out_z);
				check_field("out_qw", want.out_qw, result.out_qw);
				check_field("out_qx", want.out_qx, result.out_qx);
				check_field("out_qy", want.out_qy, result.out_qy);
				check_field("out_qz", want.out_qz, result.out_qz);
			end
		end
	end

	initial begin
		int cur;
		bit tame;
		pose_in_t pin;
		logic [63:0] pat;
		row_cfg[0] = ROW0_RST;
		row_cfg[1] = ROW1_RST;
		row_cfg[2] = ROW2_RST;
		bias_ofs_cfg = BIAS_OFS_RST;
		reg_quat_cfg = QUAT_RST;
		bias_quat_cfg = QUAT_RST;
		arst_n <= 1'b0;
		start <= 1'b0;
		pose <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ROW0;
		cfg_data <= '0;

		// reset registers are the identity: every pose comes out unchanged
		add_row(0, 1, {32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
			{32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
		add_row(0, 1, {32'h1, 16'h0100, 16'hFF00, 16'h0080, 16'h2000, 16'h0, 16'h0, 16'h0},
			{32'h1, 16'h0100, 16'hFF00, 16'h0080, 16'h2000, 16'h0, 16'h0, 16'h0});
		add_row(0, 1, {32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
			{32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
		add_row(0, 1, {32'h8000_0000, 16'h8000, 16'h7FFF, 16'h8000,
			16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
			{32'h8000_0000, 16'h8000, 16'h7FFF, 16'h8000,
			16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
		add_row(0, 1, {32'h5555_5555, {7{16'h5555}}}, {32'h5555_5555, {7{16'h5555}}});
		add_row(0, 1, {32'hAAAA_AAAA, {7{16'hAAAA}}}, {32'hAAAA_AAAA, {7{16'hAAAA}}});
		// rotated registration with bias
		add_row(1, 0, {32'h10, 16'h0100, 16'h0200, 16'h0300, 16'h2000, 16'h0, 16'h0, 16'h0},
			'0);
		add_row(1, 0, {32'h11, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h4000, 16'h4000, 16'h4000},
			'0);
		add_row(1, 0, {32'h12, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, '0);
		add_row(1, 0, {32'h13, 16'h0400, 16'hFC00, 16'h0200, 16'h16A1, 16'h0, 16'h0, 16'h16A1},
			'0);
		add_row(1, 0, {32'h14, 16'hFF00, 16'h0100, 16'h0, 16'hE000, 16'h0, 16'h0, 16'h0}, '0);
		add_row(1, 0, {32'hFFFF_FFFE, 16'h7FFF, 16'h8000, 16'h7FFF, {4{16'h8000}}}, '0);
		add_row(1, 0, {32'h15, 16'h8000, 16'h7FFF, 16'h8000, {4{16'h7FFF}}}, '0);
		// everything at full scale: both saturation paths
		add_row(2, 0, {32'h20, {3{16'h7FFF}}, 16'h2000, 16'h0, 16'h0, 16'h0}, '0);
		add_row(2, 0, {32'h21, {3{16'h8000}}, 16'h2000, 16'h0, 16'h0, 16'h0}, '0);
		add_row(2, 0, {32'h22, {3{16'h0}}, {4{16'h7FFF}}}, '0);
		add_row(2, 0, {32'h23, {3{16'h0}}, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur = 0;
		for (int k = 0; k < dir_rows.size(); k++) begin
			if (dir_rows[k].phase != cur) begin
				settle();
				cur = dir_rows[k].phase;
				if (cur == 1)
					// 90 deg about z; bias write carries junk above bit 47
					apply_config({16'h0100, 16'h0000, 16'hE000, 16'h0000},
						{16'hFF00, 16'h0000, 16'h0000, 16'h2000},
						{16'h0080, 16'h2000, 16'h0000, 16'h0000},
						{16'hDEAD, 16'h0080, 16'hFF00, 16'h0100},
						{16'h16A1, 16'h0000, 16'h0000, 16'h16A1},
						{16'h0000, 16'h0000, 16'h16A1, 16'h16A1}, 1'b1);
				else
					apply_config({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}},
						{4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 1'b0);
			end
			send_pose(dir_rows[k].pin,
				dir_rows[k].typed ? dir_rows[k].want : register_pose(dir_rows[k].pin));
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			case (ph)
				0: apply_config(ROW0_RST, ROW1_RST, ROW2_RST, {16'h0, BIAS_OFS_RST},
					QUAT_RST, QUAT_RST, 1'b1);
				1, 2, 3, 4: begin
					pat = (ph == 1) ? {4{16'h7FFF}} : (ph == 2) ? {4{16'h8000}} :
						(ph == 3) ? 64'h0 : {4{16'hFFFF}};
					apply_config(pat, pat, pat, pat, pat, pat, 1'b0);
				end
				default: begin
					tame = ($urandom_range(0, 2) != 0);
					apply_config(
						{rand_word(), rand_lane(tame), rand_lane(tame), rand_lane(tame)},
						{rand_word(), rand_lane(tame), rand_lane(tame), rand_lane(tame)},
						{rand_word(), rand_lane(tame), rand_lane(tame), rand_lane(tame)},
						{16'($urandom), rand_word(), rand_word(), rand_word()},
						{rand_lane(tame), rand_lane(tame), rand_lane(tame), rand_lane(tame)},
						{rand_lane(tame), rand_lane(tame), rand_lane(tame), rand_lane(tame)},
						$urandom_range(0, 1) != 0);
				end
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				tame = ($urandom_range(0, 1) != 0);
				pin.stamp = $urandom;
				pin.raw_x = rand_word();
				pin.raw_y = rand_word();
				pin.raw_z = rand_word();
				pin.raw_qw = rand_lane(tame);
				pin.raw_qx = rand_lane(tame);
				pin.raw_qy = rand_lane(tame);
				pin.raw_qz = rand_lane(tame);
				send_pose(pin, register_pose(pin));
			end
		end

		settle();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
